FILE: rtl/udic_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and identifier classify: shared package
// Byte constants, the queue entry type and the identifier class functions.
// ----------------------------------------------------------------------------
package udic_pkg;

    localparam int CP_W = 21;

    localparam logic [7:0] BYTE_CONT_LO = 8'h80;
    localparam logic [7:0] BYTE_CONT_HI = 8'hC0;   // exclusive
    localparam logic [7:0] BYTE_LEAD_LO = 8'hC2;
    localparam logic [7:0] BYTE_LEAD_3  = 8'hE0;
    localparam logic [7:0] BYTE_LEAD_4  = 8'hF0;
    localparam logic [7:0] BYTE_BAD_HI  = 8'hF5;
    localparam logic [7:0] CONT_MASK    = 8'h3F;

    localparam logic [1:0] REM_2B = 2'd1;
    localparam logic [1:0] REM_3B = 2'd2;
    localparam logic [1:0] REM_4B = 2'd3;
    localparam logic [2:0] LEN_2B = 3'd2;
    localparam logic [2:0] LEN_3B = 3'd3;
    localparam logic [2:0] LEN_4B = 3'd4;

    localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [CP_W-1:0] LIM_2B   = 21'h000800;
    localparam logic [CP_W-1:0] LIM_3B   = 21'h010000;
    localparam logic [CP_W-1:0] SUPP_HI  = 21'h0EFFFD;
    localparam logic [15:0]     PLANE_NC = 16'hFFFD;

    localparam int N_CONT    = 31;
    localparam int N_NOSTART = 4;

    localparam logic [CP_W-1:0] CONT_LO [N_CONT] = '{
        21'h00A8, 21'h00AA, 21'h00AD, 21'h00AF, 21'h00B2, 21'h00B7, 21'h00BC,
        21'h00C0, 21'h00D8, 21'h00F8, 21'h0100, 21'h1681, 21'h180F, 21'h200B,
        21'h202A, 21'h203F, 21'h2054, 21'h2060, 21'h2070, 21'h2460, 21'h2776,
        21'h2C00, 21'h2E80, 21'h3004, 21'h3021, 21'h3031, 21'h3040, 21'hF900,
        21'hFD40, 21'hFDF0, 21'hFE47
    };
    localparam logic [CP_W-1:0] CONT_HI [N_CONT] = '{
        21'h00A8, 21'h00AA, 21'h00AD, 21'h00AF, 21'h00B5, 21'h00BA, 21'h00BE,
        21'h00D6, 21'h00F6, 21'h00FF, 21'h167F, 21'h180D, 21'h1FFF, 21'h200D,
        21'h202E, 21'h2040, 21'h2054, 21'h206F, 21'h218F, 21'h24FF, 21'h2793,
        21'h2DFF, 21'h2FFF, 21'h3007, 21'h302F, 21'h303F, 21'hD7FF, 21'hFD3D,
        21'hFDCF, 21'hFE44, 21'hFFF8
    };
    localparam logic [CP_W-1:0] NOSTART_LO [N_NOSTART] = '{
        21'h0300, 21'h1DC0, 21'h20D0, 21'hFE20
    };
    localparam logic [CP_W-1:0] NOSTART_HI [N_NOSTART] = '{
        21'h036F, 21'h1DFF, 21'h20FF, 21'hFE2F
    };

    // One queue entry: all results caused by one input byte.
    // A second result only ever follows a broken sequence and is an ASCII
    // byte or an invalid lead, so seven bits carry it.
    typedef struct packed {
        logic [CP_W-1:0] first_cp;
        logic            first_ok;
        logic            has_second;
        logic [6:0]      second_cp;
        logic            second_ok;
    } t_qent;

    typedef struct packed {
        logic  push;
        t_qent ent;
    } t_push;

    function automatic logic is_start_byte(input logic [7:0] b);
        return !b[7] || (b >= BYTE_LEAD_LO && b < BYTE_BAD_HI);
    endfunction

    function automatic logic is_digit(input logic [CP_W-1:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic may_continue(input logic [CP_W-1:0] c);
        logic hit;
        hit = 1'b0;
        if (c < 21'h80) begin
            hit = (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
                  is_digit(c) || c == 21'h5F || c == 21'h24;
        end else if (c >= LIM_3B && c <= SUPP_HI) begin
            hit = c[15:0] <= PLANE_NC;
        end else begin
            for (int i = 0; i < N_CONT; i++) begin
                if (c >= CONT_LO[i] && c <= CONT_HI[i]) hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic may_start(input logic [CP_W-1:0] c);
        logic hit;
        hit = may_continue(c);
        if (c < 21'h80 && (is_digit(c) || c == 21'h24)) hit = 1'b0;
        for (int i = 0; i < N_NOSTART; i++) begin
            if (c >= NOSTART_LO[i] && c <= NOSTART_HI[i]) hit = 1'b0;
        end
        return hit;
    endfunction

endpackage

FILE: rtl/udic_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and identifier classify: channel interfaces
// Byte input channel and classified code point output channel.
// ----------------------------------------------------------------------------
interface udic_in_if import udic_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_marker;

    modport source (output valid, data_byte, end_marker, input ready);
    modport sink   (input valid, data_byte, end_marker, output ready);
endinterface

interface udic_out_if import udic_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            valid_res;
    logic            ident_start;
    logic            ident_continue;
    logic            last;

    modport source (output valid, code_point, valid_res, ident_start, ident_continue,
                    last, input ready);
    modport sink   (input valid, code_point, valid_res, ident_start, ident_continue,
                    last, output ready);
endinterface

FILE: rtl/utf8_decode_identifier_classify_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and identifier classify: top level
// Validating UTF-8 decoder with identifier start/continue classification.
// ----------------------------------------------------------------------------
// Use:
//   i_in  carries one raw byte per transaction (data_byte) plus end_marker;
//         an end marker flushes an open sequence as one invalid result.
//   o_out carries one code point per transaction with valid_res, the two
//         identifier class flags and last, set on the final result of a byte.
//   A byte gives zero, one or two results; a broken sequence gives an
//   invalid result followed by the result of the same byte taken as a lead.
// Path: a byte taken on i_in is decoded into the queue, then classified into
//   the output register, from which o_out presents its result.
// Throughput: one byte per cycle and one result per cycle while the queue has
//   space and o_out.ready is high; a two-result byte holds its queue entry
//   until both results are taken, and the QDEPTH-entry queue soaks up such bursts.
// Reset (synchronous, active low) empties the queue and output register and
//   returns the decoder to idle with resync cleared.
// Stall: when o_out.ready is low the output register holds, the queue fills
//   and i_in.ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module utf8_decode_identifier_classify_unit import udic_pkg::*; #(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    udic_in_if.sink     i_in,
    udic_out_if.source  o_out
);

    t_push push;
    t_qent head;
    logic  q_space;
    logic  q_nonempty;
    logic  pop;

    // decoder state machine: bytes in, per-byte result entries out
    udic_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_space (q_space),
        .o_push    (push)
    );

    // decouples the decoder from output back-pressure
    udic_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_space    (q_space),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    // result split, identifier range compare and output register
    udic_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

FILE: rtl/udic_front.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and identifier classify: front end
// Accepts bytes, runs the sequence decoder and pushes the results per byte.
// ----------------------------------------------------------------------------
module udic_front import udic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    udic_in_if.sink     i_in,
    input  logic        i_q_space,
    output t_push       o_push
);

    logic [1:0]      r_rem,  n_rem;
    logic [2:0]      r_len,  n_len;
    logic [CP_W-1:0] r_acc,  n_acc;
    logic            r_skip, n_skip;

    logic [7:0]      b;
    logic            accept;
    logic            lead_go;
    logic            lead_slot;
    logic [CP_W-1:0] acc_new;
    logic            acc_ok;
    t_push           push;

    assign i_in.ready = i_q_space;
    assign accept     = i_in.valid && i_q_space;
    assign b          = i_in.data_byte;
    assign acc_new    = {r_acc[CP_W-7:0], b[5:0] & CONT_MASK[5:0]};

    always_comb begin
        acc_ok = !(acc_new >= SURR_LO && acc_new <= SURR_HI) && acc_new <= CP_MAX;
        if (acc_new < LIM_2B)      acc_ok = acc_ok && r_len == LEN_2B;
        else if (acc_new < LIM_3B) acc_ok = acc_ok && r_len == LEN_3B;
        else                       acc_ok = acc_ok && r_len == LEN_4B;
    end

    always_comb begin
        n_rem     = r_rem;
        n_len     = r_len;
        n_acc     = r_acc;
        n_skip    = r_skip;
        push      = '0;
        lead_go   = 1'b0;
        lead_slot = 1'b0;
        if (accept) begin
            if (i_in.end_marker) begin
                push.push = r_rem != 2'd0;
                n_rem     = '0;
                n_len     = '0;
                n_acc     = '0;
                n_skip    = 1'b0;
            end else if (r_skip) begin
                if (is_start_byte(b)) begin
                    n_skip  = 1'b0;
                    lead_go = 1'b1;
                end
            end else if (r_rem != 2'd0) begin
                if (b >= BYTE_CONT_LO && b < BYTE_CONT_HI) begin
                    n_acc = acc_new;
                    n_rem = r_rem - 2'd1;
                    if (r_rem == 2'd1) begin
                        push.push         = 1'b1;
                        push.ent.first_ok = acc_ok;
                        push.ent.first_cp = acc_ok ? acc_new : '0;
                        n_len             = '0;
                        n_acc             = '0;
                    end
                end else begin
                    // broken sequence: report it, then take the byte as a lead
                    push.push = 1'b1;
                    n_rem     = '0;
                    n_len     = '0;
                    n_acc     = '0;
                    lead_go   = 1'b1;
                    lead_slot = 1'b1;
                end
            end else begin
                lead_go = 1'b1;
            end
        end

        if (lead_go) begin
            if (!b[7] || !is_start_byte(b)) begin
                if (!is_start_byte(b)) n_skip = 1'b1;
                if (lead_slot) begin
                    push.ent.has_second = 1'b1;
                    push.ent.second_ok  = !b[7];
                    push.ent.second_cp  = b[7] ? 7'd0 : b[6:0];
                end else begin
                    push.push         = 1'b1;
                    push.ent.first_ok = !b[7];
                    push.ent.first_cp = b[7] ? '0 : CP_W'(b[6:0]);
                end
            end else if (b < BYTE_LEAD_3) begin
                n_len = LEN_2B;
                n_rem = REM_2B;
                n_acc = CP_W'(b[4:0]);
            end else if (b < BYTE_LEAD_4) begin
                n_len = LEN_3B;
                n_rem = REM_3B;
                n_acc = CP_W'(b[3:0]);
            end else begin
                n_len = LEN_4B;
                n_rem = REM_4B;
                n_acc = CP_W'(b[2:0]);
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_len  <= '0;
            r_acc  <= '0;
            r_skip <= 1'b0;
        end else begin
            r_rem  <= n_rem;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_skip <= n_skip;
        end
    end

    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_rem == 2'd0)
        else $error("front: resync while a sequence is open");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem == 2'd0 |-> (r_acc == '0 && r_len == 3'd0))
        else $error("front: idle with stale accumulator");

endmodule

FILE: rtl/udic_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and identifier classify: result queue
// Small FIFO of per-byte result entries between front and back end.
// ----------------------------------------------------------------------------
module udic_queue import udic_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_space,
    output logic  o_nonempty,
    output t_qent o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qent         r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_space    = r_cnt != CW'(DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push.push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) r_mem[r_wr] <= i_push.ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CW'(DEPTH) |-> !i_push.push)
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !i_pop)
        else $error("queue: pop while empty");

endmodule

FILE: rtl/udic_back.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and identifier classify: back end
// Splits queue entries into results, classifies them, holds the output.
// ----------------------------------------------------------------------------
module udic_back import udic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nonempty,
    input  t_qent       i_head,
    output logic        o_pop,
    udic_out_if.source  o_out
);

    logic            r_sel;
    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_ok;
    logic            r_start;
    logic            r_cont;
    logic            r_last;

    logic            load;
    logic [CP_W-1:0] cur_cp;
    logic            cur_ok;
    logic            cur_last;

    assign load     = i_nonempty && (!r_valid || o_out.ready);
    assign cur_cp   = r_sel ? CP_W'(i_head.second_cp) : i_head.first_cp;
    assign cur_ok   = r_sel ? i_head.second_ok : i_head.first_ok;
    assign cur_last = r_sel || !i_head.has_second;
    assign o_pop    = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_sel   <= !cur_last;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp    <= cur_ok ? cur_cp : '0;
            r_ok    <= cur_ok;
            r_start <= cur_ok && may_start(cur_cp);
            r_cont  <= cur_ok && may_continue(cur_cp);
            r_last  <= cur_last;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.code_point     = r_cp;
    assign o_out.valid_res      = r_ok;
    assign o_out.ident_start    = r_start;
    assign o_out.ident_continue = r_cont;
    assign o_out.last           = r_last;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (r_cp == '0 && !r_start && !r_cont))
        else $error("back: invalid result carries data");

    a_start_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_start) |-> r_cont)
        else $error("back: start class without continue class");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 decode and identifier classify: block-level testbench
// Streams raw bytes into the decoder and checks every classified code point
// against an independent decoder model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
package udic_tb_pkg;

    // Identifier continuation ranges above ASCII, outside the supplementary
    // planes (those are handled by the per-plane rule).
    localparam int N_EXT = 31;
    localparam bit [20:0] EXT_FROM [N_EXT] = '{
        21'h00A8, 21'h00AA, 21'h00AD, 21'h00AF, 21'h00B2, 21'h00B7, 21'h00BC,
        21'h00C0, 21'h00D8, 21'h00F8, 21'h0100, 21'h1681, 21'h180F, 21'h200B,
        21'h202A, 21'h203F, 21'h2054, 21'h2060, 21'h2070, 21'h2460, 21'h2776,
        21'h2C00, 21'h2E80, 21'h3004, 21'h3021, 21'h3031, 21'h3040, 21'hF900,
        21'hFD40, 21'hFDF0, 21'hFE47
    };
    localparam bit [20:0] EXT_TO [N_EXT] = '{
        21'h00A8, 21'h00AA, 21'h00AD, 21'h00AF, 21'h00B5, 21'h00BA, 21'h00BE,
        21'h00D6, 21'h00F6, 21'h00FF, 21'h167F, 21'h180D, 21'h1FFF, 21'h200D,
        21'h202E, 21'h2040, 21'h2054, 21'h206F, 21'h218F, 21'h24FF, 21'h2793,
        21'h2DFF, 21'h2FFF, 21'h3007, 21'h302F, 21'h303F, 21'hD7FF, 21'hFD3D,
        21'hFDCF, 21'hFE44, 21'hFFF8
    };
    // Combining marks: may continue but never begin an identifier
    localparam int N_MARK = 4;
    localparam bit [20:0] MARK_FROM [N_MARK] = '{21'h0300, 21'h1DC0, 21'h20D0, 21'hFE20};
    localparam bit [20:0] MARK_TO   [N_MARK] = '{21'h036F, 21'h1DFF, 21'h20FF, 21'hFE2F};

    typedef struct packed {
        logic [20:0] cp;
        logic        ok;
        logic        id_start;
        logic        id_cont;
        logic        last;
    } t_cp_result;

    class utf8_scoreboard;
        bit [1:0]   cont_left;
        bit [2:0]   seq_len;
        bit [20:0]  acc;
        bit         skipping;
        t_cp_result expected_q[$];
        t_cp_result step_q[$];
        int         mismatches;

        function new();
            go_idle();
            skipping   = 1'b0;
            mismatches = 0;
        endfunction

        local function void go_idle();
            cont_left = 2'd0;
            seq_len   = 3'd0;
            acc       = '0;
        endfunction

        local function bit is_digit(bit [20:0] c);
            return c >= 21'h30 && c <= 21'h39;
        endfunction

        local function bit may_extend(bit [20:0] c);
            if (c < 21'h80)
                return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
                       is_digit(c) || c == 21'h5F || c == 21'h24;
            if (c >= 21'h10000 && c <= 21'hEFFFD)
                return c[15:0] <= 16'hFFFD;
            for (int i = 0; i < N_EXT; i++)
                if (c >= EXT_FROM[i] && c <= EXT_TO[i]) return 1'b1;
            return 1'b0;
        endfunction

        local function bit may_begin(bit [20:0] c);
            if (!may_extend(c)) return 1'b0;
            if (is_digit(c) || c == 21'h24) return 1'b0;
            for (int i = 0; i < N_MARK; i++)
                if (c >= MARK_FROM[i] && c <= MARK_TO[i]) return 1'b0;
            return 1'b1;
        endfunction

        local function bit lead_ok(bit [7:0] b);
            return !b[7] || (b >= 8'hC2 && b < 8'hF5);
        endfunction

        local function bit well_formed(bit [20:0] v, bit [2:0] len);
            bit [2:0] need;
            if (v >= 21'hD800 && v <= 21'hDFFF) return 1'b0;
            if (v > 21'h10FFFF) return 1'b0;
            need = (v < 21'h800) ? 3'd2 : (v < 21'h10000) ? 3'd3 : 3'd4;
            return need == len;
        endfunction

        local function void push_cp(bit [20:0] c, bit ok);
            t_cp_result r;
            r = '0;
            if (ok) begin
                r.cp       = c;
                r.ok       = 1'b1;
                r.id_start = may_begin(c);
                r.id_cont  = may_extend(c);
            end
            step_q = {step_q, r};
        endfunction

        local function void take_lead(bit [7:0] b);
            if (!b[7]) begin
                push_cp({13'd0, b}, 1'b1);
            end else if (!lead_ok(b)) begin
                push_cp('0, 1'b0);
                skipping = 1'b1;
            end else if (b < 8'hE0) begin
                seq_len = 3'd2; cont_left = 2'd1; acc = {16'd0, b[4:0]};
            end else if (b < 8'hF0) begin
                seq_len = 3'd3; cont_left = 2'd2; acc = {17'd0, b[3:0]};
            end else begin
                seq_len = 3'd4; cont_left = 2'd3; acc = {18'd0, b[2:0]};
            end
        endfunction

        // Advance the decoder by one accepted byte and queue its results
        function void note_byte(bit [7:0] b, bit eob);
            int idx;
            step_q.delete();
            if (eob) begin
                if (cont_left != 0) push_cp('0, 1'b0);
                go_idle();
                skipping = 1'b0;
            end else if (skipping) begin
                if (lead_ok(b)) begin
                    skipping = 1'b0;
                    take_lead(b);
                end
            end else if (cont_left != 0) begin
                if (b[7:6] == 2'b10) begin
                    acc = {acc[14:0], b[5:0]};
                    cont_left--;
                    if (cont_left == 0) begin
                        push_cp(acc, well_formed(acc, seq_len));
                        go_idle();
                    end
                end else begin
                    // broken sequence: error, then the byte starts afresh
                    push_cp('0, 1'b0);
                    go_idle();
                    take_lead(b);
                end
            end else begin
                take_lead(b);
            end
            if (step_q.size() > 0) begin
                idx = step_q.size() - 1;
                step_q[idx].last = 1'b1;
            end
            expected_q = {expected_q, step_q};
        endfunction

        function void check_result(t_cp_result got);
            t_cp_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: code_point %h valid_res %b", got.cp, got.ok);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.cp !== want.cp) begin
                $error("code_point: expected %h, got %h", want.cp, got.cp);
                mismatches++;
            end
            if (got.ok !== want.ok) begin
                $error("valid_res: expected %b, got %b", want.ok, got.ok);
                mismatches++;
            end
            if (got.id_start !== want.id_start) begin
                $error("ident_start: expected %b, got %b", want.id_start, got.id_start);
                mismatches++;
            end
            if (got.id_cont !== want.id_cont) begin
                $error("ident_continue: expected %b, got %b", want.id_cont, got.id_cont);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void flag_leftovers();
            if (expected_q.size() != 0) begin
                $error("%0d expected results never arrived", expected_q.size());
                mismatches++;
            end
        endfunction
    endclass

endpackage

module testbench import udic_tb_pkg::*; ();

    localparam int N_RANDOM = 750;

    logic i_clk = 1'b0;
    logic i_rst_n;

    udic_in_if  in_if();
    udic_out_if out_if();

    utf8_decode_identifier_classify_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    utf8_scoreboard sb = new();

    // Stimulus controls; hold_req is shared with the receiver process
    int n_sent     = 0;
    int burst_left = 0;      // transactions still to send without gaps
    bit hold_req   = 1'b0;   // asks the receiver for one long hold-off

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // One input transaction. Valid stays high after acceptance so that a
    // gap-free follow-on is a single change at the next falling edge.
    task automatic send_byte(input bit [7:0] b, input bit eob = 1'b0);
        int gap;
        gap = (burst_left > 0) ? 0 : pick_gap();
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.end_marker <= eob;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_byte(b, eob);
        n_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Encode cp in len bytes; a len longer than needed gives an overlong form
    task automatic send_cp(input bit [20:0] cp, input int len);
        case (len)
            1: send_byte({1'b0, cp[6:0]});
            2: begin
                send_byte({3'b110, cp[10:6]});
                send_byte({2'b10, cp[5:0]});
            end
            3: begin
                send_byte({4'b1110, cp[15:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
            default: begin
                send_byte({5'b11110, cp[20:18]});
                send_byte({2'b10, cp[17:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Code points biased towards class boundaries and the error regions
    function automatic bit [20:0] pick_cp();
        int        i;
        bit [20:0] base;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                i    = $urandom_range(0, N_EXT - 1);
                base = $urandom_range(0, 1) ? EXT_FROM[i] : EXT_TO[i];
                return 21'(base + $urandom_range(0, 2) - 1);
            end
            3: begin
                i    = $urandom_range(0, N_MARK - 1);
                base = $urandom_range(0, 1) ? MARK_FROM[i] : MARK_TO[i];
                return 21'(base + $urandom_range(0, 2) - 1);
            end
            4: return 21'($urandom_range(21'h80, 21'h7FF));
            5: return 21'($urandom_range(21'h800, 21'hFFFF));
            6: return 21'($urandom_range(21'hD7FE, 21'hE001));
            7: return 21'($urandom_range(21'h10000, 21'h10FFFF));
            8: return {5'($urandom_range(1, 16)), 16'hFFFC} + 21'($urandom_range(0, 3));
            default: return 21'($urandom_range(21'h10FFFE, 21'h1FFFFF));
        endcase
    endfunction

    // A lead byte followed by fewer continuation bytes than it asks for
    task automatic send_truncated();
        bit [7:0] lead;
        int       need;
        lead = 8'($urandom_range(8'hC2, 8'hF4));
        need = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
        send_byte(lead);
        repeat ($urandom_range(0, need - 1)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    // One random character: mostly well-formed, the rest noise and breakage
    task automatic send_random_char();
        bit [20:0] cp;
        int        len;
        int        r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            cp = 21'($urandom_range(0, 127));
            send_cp(cp, ($urandom_range(0, 9) == 0) ? 2 : 1);
        end else if (r < 75) begin
            cp  = pick_cp();
            len = (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            if (len < 4 && $urandom_range(0, 9) == 0) len++;
            send_cp(cp, len);
        end else if (r < 85) begin
            // truncated sequence cut short by a non-continuation byte
            send_truncated();
            send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                           : 8'($urandom_range(8'hC0, 8'hFF)));
        end else if (r < 95) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1)) send_truncated();
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Receiver: random ready pattern, with long clean runs and one forced
    // hold-off when asked for
    initial begin
        int run;
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (79) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
                repeat (run) begin
                    @(negedge i_clk);
                    out_if.ready <= 1'b1;
                end
                stall = pick_gap();
                repeat (stall) begin
                    @(negedge i_clk);
                    out_if.ready <= 1'b0;
                end
            end
        end
    end

    // Result monitor: sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result({out_if.code_point, out_if.valid_res, out_if.ident_start,
                             out_if.ident_continue, out_if.last});
    end

    // Watchdog
    initial begin
        #2000000;
        $display("utf8_decode_identifier_classify_unit test failed");
        $finish;
    end

    initial begin
        bit hold_done;
        bit pause_done;
        hold_done        = 1'b0;
        pause_done       = 1'b0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        in_if.end_marker = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ASCII letter and dollar
        send_byte(8'h41);
        send_byte(8'h24);
        // combining mark U+0300: continues, never starts
        send_byte(8'hCC); send_byte(8'h80);
        // surrogate
        send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
        // just above the last scalar value
        send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
        // overlong three-byte form of zero
        send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
        // bad lead, then a stray continuation dropped during resync
        send_byte(8'hFF);
        send_byte(8'h80);
        // four-byte sequence broken by a digit: error then the digit
        send_byte(8'hF0); send_byte(8'h90); send_byte(8'h30);
        // end of buffer with a sequence open, then with nothing open
        send_byte(8'hC3);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        // field extremes and an invalid two-byte lead
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hC1);

        // Random stream
        while (n_sent < N_RANDOM + 25) begin
            if (!hold_done && n_sent > 250) begin
                // receiver stops for a long stretch while bytes keep coming,
                // so the queue fills and input ready drops
                hold_done  = 1'b1;
                hold_req   = 1'b1;
                burst_left = 40;
            end else if (!pause_done && n_sent > 500) begin
                pause_done = 1'b1;
                drop_valid();
                wait_drained();
            end else if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(20, 40);
            end
            send_random_char();
        end

        drop_valid();
        wait_drained();
        repeat (10) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0)
            $display("utf8_decode_identifier_classify_unit test passed");
        else
            $display("utf8_decode_identifier_classify_unit test failed");
        $finish;
    end

endmodule
